### rtl/irc_pkg.sv
package irc_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int PAIRS_MAX = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
  localparam int INV_W     = $clog2(PAIRS_MAX + 1);
  localparam int NUM_W     = INV_W + 16;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 16;
  localparam int TOTAL_W   = 11;
  localparam int TOTAL_SAT = 2047;
  localparam int COEF_ONE  = 32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] key_sample;
    logic signed [SAMPLE_W-1:0] value_sample;
    logic                       last_item;
  } item_t;

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [INV_W-1:0] inv);
    logic [TOTAL_W-1:0] res;
    if (32'(inv) > 32'(TOTAL_SAT)) begin
      res = TOTAL_W'(TOTAL_SAT);
    end else begin
      res = TOTAL_W'(inv);
    end
    return res;
  endfunction

endpackage

### rtl/irc_if.sv
interface irc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [irc_pkg::SAMPLE_W-1:0]    key_sample;
  logic signed [irc_pkg::SAMPLE_W-1:0]    value_sample;
  logic                                   last_item;

  modport source(output valid, key_sample, value_sample, last_item, input ready);
  modport sink(input valid, key_sample, value_sample, last_item, output ready);
endinterface

interface irc_out_if;
  logic                          valid;
  logic                          ready;
  logic [irc_pkg::COEF_W-1:0]    coefficient;
  logic [irc_pkg::TOTAL_W-1:0]   inversion_total;
  logic                          result_valid;
  logic                          overflow_flag;

  modport source(output valid, coefficient, inversion_total, result_valid, overflow_flag,
                 input ready);
  modport sink(input valid, coefficient, inversion_total, result_valid, overflow_flag,
               output ready);
endinterface

### rtl/irc_front.sv
module irc_front (
  input  logic      clk,
  input  logic      rst,
  irc_in_if.sink    in_ch,
  irc_in_if.source  q_ch
);

  irc_pkg::item_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;
  irc_pkg::item_t head;

  assign in_ch.ready = (fill != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_ch.valid  = (fill != 2'd0);
  assign pop         = q_ch.valid && q_ch.ready;

  assign head             = entry[rd_ptr];
  assign q_ch.key_sample   = head.key_sample;
  assign q_ch.value_sample = head.value_sample;
  assign q_ch.last_item    = head.last_item;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{key_sample: in_ch.key_sample, value_sample: in_ch.value_sample,
                         last_item: in_ch.last_item};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### rtl/irc_back.sv
module irc_back (
  input  logic      clk,
  input  logic      rst,
  irc_in_if.sink    q_ch,
  irc_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PAIRS = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state;

  logic signed [irc_pkg::SAMPLE_W-1:0] key_mem [irc_pkg::MAX_ITEMS];
  logic signed [irc_pkg::SAMPLE_W-1:0] val_mem [irc_pkg::MAX_ITEMS];
  logic signed [irc_pkg::SAMPLE_W-1:0] key_q;
  logic signed [irc_pkg::SAMPLE_W-1:0] val_q;

  logic signed [irc_pkg::SAMPLE_W-1:0] cur_key;
  logic signed [irc_pkg::SAMPLE_W-1:0] cur_val;
  logic                                cur_last;

  logic [irc_pkg::CNT_W-1:0]     item_count;
  logic [irc_pkg::CNT_W-1:0]     rd_addr;
  logic                          rd_pend;
  logic [irc_pkg::INV_W-1:0]     inv;
  logic                          dropped;
  logic [irc_pkg::INV_W-1:0]     pairs;
  logic [irc_pkg::NUM_W-1:0]     num;
  logic [irc_pkg::INV_W:0]       rem;
  logic [irc_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          res_ok;

  logic                          take;
  logic                          hit;
  logic                          store;
  logic [2*irc_pkg::CNT_W-1:0]   prod;
  logic [irc_pkg::INV_W:0]       rem_sh;
  logic                          q_bit;
  logic                          load_out;

  assign q_ch.ready = (state == ST_IDLE);
  assign take       = q_ch.valid && q_ch.ready;

  // stored pair earlier in order when its key is smaller, otherwise new pair is earlier
  assign hit = (key_q < cur_key) ? (val_q > cur_val) : (cur_val > val_q);

  assign store = (state == ST_SCAN) && (rd_addr == item_count) && !rd_pend;
  assign prod  = item_count * (item_count - irc_pkg::CNT_W'(1));

  assign rem_sh = {rem[irc_pkg::INV_W-1:0], num[irc_pkg::NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, pairs});

  assign load_out = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (store) begin
      key_mem[item_count[irc_pkg::ADDR_W-1:0]] <= cur_key;
      val_mem[item_count[irc_pkg::ADDR_W-1:0]] <= cur_val;
    end
    key_q <= key_mem[rd_addr[irc_pkg::ADDR_W-1:0]];
    val_q <= val_mem[rd_addr[irc_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_key  <= q_ch.key_sample;
      cur_val  <= q_ch.value_sample;
      cur_last <= q_ch.last_item;
    end
    if (state == ST_PAIRS) begin
      pairs <= irc_pkg::INV_W'(prod >> 1);
    end
    if (state == ST_PREP) begin
      num <= (irc_pkg::NUM_W'(pairs - inv) << 15) + irc_pkg::NUM_W'(pairs >> 1);
      rem <= '0;
    end else if (state == ST_DIV) begin
      num <= {num[irc_pkg::NUM_W-2:0], q_bit};
      rem <= q_bit ? (rem_sh - {1'b0, pairs}) : rem_sh;
    end
    if (load_out) begin
      out_ch.coefficient     <= res_ok ? num[irc_pkg::COEF_W-1:0] : '0;
      out_ch.inversion_total <= res_ok ? irc_pkg::sat_total(inv) : '0;
      out_ch.result_valid    <= res_ok;
      out_ch.overflow_flag   <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      item_count   <= '0;
      rd_addr      <= '0;
      rd_pend      <= 1'b0;
      inv          <= '0;
      dropped      <= 1'b0;
      div_cnt      <= '0;
      res_ok       <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          rd_addr <= '0;
          rd_pend <= 1'b0;
          if (take) begin
            if (item_count == irc_pkg::CNT_W'(irc_pkg::MAX_ITEMS)) begin
              // store full: drop the pair
              dropped <= 1'b1;
              state   <= q_ch.last_item ? ST_PAIRS : ST_IDLE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_pend && hit) inv <= inv + irc_pkg::INV_W'(1);
          if (rd_addr != item_count) begin
            rd_addr <= rd_addr + irc_pkg::CNT_W'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (store) begin
            item_count <= item_count + irc_pkg::CNT_W'(1);
            state      <= cur_last ? ST_PAIRS : ST_IDLE;
          end
        end
        ST_PAIRS: begin
          res_ok  <= (item_count >= irc_pkg::CNT_W'(2));
          state   <= (item_count >= irc_pkg::CNT_W'(2)) ? ST_PREP : ST_DONE;
        end
        ST_PREP: begin
          div_cnt <= irc_pkg::DIV_CNT_W'(irc_pkg::NUM_W);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt - irc_pkg::DIV_CNT_W'(1);
          if (div_cnt == irc_pkg::DIV_CNT_W'(1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            item_count   <= '0;
            inv          <= '0;
            dropped      <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/inversion_rank_correlation.sv
// Each queued pair is compared against every pair already stored, with one read per cycle of the
//   key and value memories, and is then written in; a pair that finds the store full is dropped.
// A last pair then runs the bit-serial coefficient divide, which is skipped when fewer than two
//   pairs are stored, and the result waits for the output to be free before the next set starts.
// The back end takes a new pair only when it is through with the last; a two-entry queue takes pairs during the work.
// Reset (synchronous, rst high) empties the queue, clears count, inversions and drop mark.
module inversion_rank_correlation (
  input  logic      clk,
  input  logic      rst,
  irc_in_if.sink    in_ch,
  irc_out_if.source out_ch
);

  irc_in_if q_ch ();

  irc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .q_ch  (q_ch)
  );

  irc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_ch   (q_ch),
    .out_ch (out_ch)
  );

endmodule

### rtl/irc_checker.sv
module irc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [irc_pkg::COEF_W-1:0]    coefficient,
  input logic [irc_pkg::TOTAL_W-1:0]   inversion_total,
  input logic                          result_valid
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient))
    else $error("stalled transaction dropped or changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_valid |-> coefficient == '0 && inversion_total == '0)
    else $error("short set must report zeros");

  a_coef_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_valid |-> 32'(coefficient) <= 32'(irc_pkg::COEF_ONE))
    else $error("coefficient above one");

  a_perfect: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_valid && inversion_total == '0 |->
      32'(coefficient) == 32'(irc_pkg::COEF_ONE))
    else $error("no inversions must give coefficient one");

endmodule

bind inversion_rank_correlation irc_checker u_irc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .coefficient     (out_ch.coefficient),
  .inversion_total (out_ch.inversion_total),
  .result_valid    (out_ch.result_valid)
);
